FILE: rtl/shps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shps_pkg: shared types and constants of the sync header packet splitter
// Widths, limits, result codes and the result record used by the RTL and the
// port checker.
// ---------------------------------------------------------------------------
package shps_pkg;

    localparam int MAX_PACKET_LEN = 200;
    localparam int MAX_SLOTS      = 30;
    localparam int MAX_RESULTS    = 5;

    localparam int BYTE_W   = 8;
    localparam int SLOT_W   = 5;
    localparam int OFFSET_W = 8;
    localparam int LEN_W    = 8;
    localparam int COUNT_W  = 5;
    localparam int KIND_W   = 2;

    // byte_count saturates at MAX_PACKET_LEN + 2
    localparam int BC_W      = $clog2(MAX_PACKET_LEN + 3);
    localparam int SI_W      = $clog2(MAX_SLOTS + 1);
    localparam int RES_IDX_W = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] HDR_FIRST_RESET  = 8'h5A;
    localparam logic [BYTE_W-1:0] HDR_SECOND_RESET = 8'hA5;

    typedef enum logic [KIND_W-1:0] {
        KIND_STORE = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_DROP  = 2'd2,
        KIND_DONE  = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HDR_FIRST  = 1'b0,
        CFG_HDR_SECOND = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        kind_t                kind;
        logic [SLOT_W-1:0]    slot;
        logic [OFFSET_W-1:0]  offset;
        logic [BYTE_W-1:0]    byte_out;
        logic [LEN_W-1:0]     packet_length;
        logic [COUNT_W-1:0]   packet_count;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/shps_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shps_if: valid/ready channels of the sync header packet splitter
// shps_rx_if carries received bytes, shps_res_if carries result records.
// ---------------------------------------------------------------------------
interface shps_rx_if;
    import shps_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface shps_res_if;
    import shps_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] offset;
    logic [BYTE_W-1:0]   byte_out;
    logic [LEN_W-1:0]    packet_length;
    logic [COUNT_W-1:0]  packet_count;
    logic                run_last;

    modport source (output valid, output kind, output slot, output offset,
                    output byte_out, output packet_length, output packet_count,
                    output run_last, input ready);
    modport sink   (input valid, input kind, input slot, input offset,
                    input byte_out, input packet_length, input packet_count,
                    input run_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/sync_header_packet_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sync_header_packet_splitter: splits a received frame into packets
// Finds two-byte headers in a byte stream, reports stored bytes with slot
// and offset, closed or dropped packets, and a frame summary.
// ---------------------------------------------------------------------------
//  channel | dir | payload                                   | handshake
//  rx      | in  | rx_byte, frame_end                        | valid/ready
//  res     | out | kind, slot, offset, byte_out,             | valid/ready
//          |     | packet_length, packet_count, run_last     |
//  cfg     | in  | cfg_index, cfg_data                       | cfg_we only
//
//  A byte is decoded in the cycle it is accepted; its results (0 to 5) sit in
//  a result list register and leave one per cycle, unless res stalls, from the
//  next cycle on. A byte with results holds rx: one byte per cycle while each
//  byte gives at most one result. The next byte is taken in the same cycle as
//  the last queued result. Reset loads the default header and clears the
//  packet state and the list; res stalls hold the list and back-pressure rx.
// ---------------------------------------------------------------------------
module sync_header_packet_splitter (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [shps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [shps_pkg::BYTE_W-1:0]     cfg_data,
    shps_rx_if.sink                              rx,
    shps_res_if.source                           res
);
    import shps_pkg::*;

    logic [BYTE_W-1:0]    hdr_first_reg;
    logic [BYTE_W-1:0]    hdr_second_reg;

    logic                 prev_hf_reg, prev_hf_next;
    logic                 in_pkt_reg, in_pkt_next;
    logic [BC_W-1:0]      byte_cnt_reg, byte_cnt_next;
    logic [SI_W-1:0]      slot_idx_reg, slot_idx_next;

    result_t              list_reg [MAX_RESULTS];
    result_t              list_next [MAX_RESULTS];
    logic [RES_IDX_W-1:0] cnt_reg, cnt_next;
    logic [RES_IDX_W-1:0] rd_idx_reg;

    logic                 rx_take;
    logic                 res_take;
    logic                 res_is_last;
    result_t              cur;

    function automatic result_t mk(kind_t k, logic [SI_W-1:0] s,
                                   logic [BC_W-1:0] ofs, logic [BYTE_W-1:0] b,
                                   logic [BC_W-1:0] len, logic [SI_W-1:0] c);
        result_t r;
        r.kind          = k;
        r.slot          = SLOT_W'(s);
        r.offset        = OFFSET_W'(ofs);
        r.byte_out      = b;
        r.packet_length = LEN_W'(len);
        r.packet_count  = COUNT_W'(c);
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg  <= HDR_FIRST_RESET;
            hdr_second_reg <= HDR_SECOND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_HDR_FIRST:  hdr_first_reg  <= cfg_data;
                CFG_HDR_SECOND: hdr_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // decode one byte into its result list and next packet state
    always_comb
    begin
        logic                 in_p;
        logic                 prev;
        logic [BC_W-1:0]      bc;
        logic [SI_W-1:0]      si;
        logic [BC_W-1:0]      len;
        logic [RES_IDX_W-1:0] n;

        in_p = in_pkt_reg;
        prev = prev_hf_reg;
        bc   = byte_cnt_reg;
        si   = slot_idx_reg;
        len  = '0;
        n    = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            list_next[i] = '0;
        end

        if (si >= SI_W'(MAX_SLOTS))
        begin
            prev = 1'b0;
            in_p = 1'b0;
        end
        else if (prev && rx.rx_byte == hdr_second_reg)
        begin
            if (in_p)
            begin
                len = bc - 1'b1;
                if (len <= BC_W'(MAX_PACKET_LEN))
                begin
                    list_next[n] = mk(KIND_CLOSE, si, '0, '0, len, '0);
                    si = si + 1'b1;
                end
                else
                begin
                    list_next[n] = mk(KIND_DROP, si, '0, '0, '0, '0);
                end
                n = n + 1'b1;
            end
            if (si < SI_W'(MAX_SLOTS))
            begin
                in_p = 1'b1;
                list_next[n] = mk(KIND_STORE, si, BC_W'(0), hdr_first_reg, '0, '0);
                n = n + 1'b1;
                list_next[n] = mk(KIND_STORE, si, BC_W'(1), rx.rx_byte, '0, '0);
                n = n + 1'b1;
                bc = BC_W'(2);
            end
            else
            begin
                in_p = 1'b0;
            end
            prev = 1'b0;
        end
        else
        begin
            if (in_p)
            begin
                if (bc < BC_W'(MAX_PACKET_LEN))
                begin
                    list_next[n] = mk(KIND_STORE, si, bc, rx.rx_byte, '0, '0);
                    n = n + 1'b1;
                end
                if (bc < BC_W'(MAX_PACKET_LEN + 2))
                begin
                    bc = bc + 1'b1;
                end
            end
            prev = (rx.rx_byte == hdr_first_reg);
        end

        if (rx.frame_end)
        begin
            if (in_p)
            begin
                if (bc <= BC_W'(MAX_PACKET_LEN))
                begin
                    list_next[n] = mk(KIND_CLOSE, si, '0, '0, bc, '0);
                    si = si + 1'b1;
                end
                else
                begin
                    list_next[n] = mk(KIND_DROP, si, '0, '0, '0, '0);
                end
                n = n + 1'b1;
            end
            list_next[n] = mk(KIND_DONE, '0, '0, '0, '0, si);
            n = n + 1'b1;
            prev = 1'b0;
            in_p = 1'b0;
            bc   = '0;
            si   = '0;
        end

        prev_hf_next  = prev;
        in_pkt_next   = in_p;
        byte_cnt_next = bc;
        slot_idx_next = si;
        cnt_next      = n;
    end

    assign res_is_last = (rd_idx_reg == cnt_reg - 1'b1);
    assign res_take    = res.valid && res.ready;
    assign rx.ready    = (cnt_reg == '0) || (res_take && res_is_last);
    assign rx_take     = rx.valid && rx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_hf_reg  <= 1'b0;
            in_pkt_reg   <= 1'b0;
            byte_cnt_reg <= '0;
            slot_idx_reg <= '0;
            cnt_reg      <= '0;
            rd_idx_reg   <= '0;
        end
        else if (rx_take)
        begin
            prev_hf_reg  <= prev_hf_next;
            in_pkt_reg   <= in_pkt_next;
            byte_cnt_reg <= byte_cnt_next;
            slot_idx_reg <= slot_idx_next;
            cnt_reg      <= cnt_next;
            rd_idx_reg   <= '0;
        end
        else if (res_take)
        begin
            if (res_is_last)
            begin
                cnt_reg    <= '0;
                rd_idx_reg <= '0;
            end
            else
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    // result list payload
    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                list_reg[i] <= list_next[i];
            end
        end
    end

    assign cur               = list_reg[rd_idx_reg];
    assign res.valid         = (cnt_reg != '0);
    assign res.kind          = cur.kind;
    assign res.slot          = cur.slot;
    assign res.offset        = cur.offset;
    assign res.byte_out      = cur.byte_out;
    assign res.packet_length = cur.packet_length;
    assign res.packet_count  = cur.packet_count;
    assign res.run_last      = res_is_last;

endmodule
`default_nettype wire

FILE: rtl/shps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shps_checker: port checks of the sync header packet splitter
// Watches the result channel and checks its records against the limits.
// ---------------------------------------------------------------------------
module shps_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           res_valid,
    input  wire logic                           res_ready,
    input  wire logic [shps_pkg::KIND_W-1:0]    res_kind,
    input  wire logic [shps_pkg::SLOT_W-1:0]    res_slot,
    input  wire logic [shps_pkg::OFFSET_W-1:0]  res_offset,
    input  wire logic [shps_pkg::LEN_W-1:0]     res_packet_length,
    input  wire logic [shps_pkg::COUNT_W-1:0]   res_packet_count,
    input  wire logic                           res_run_last
);
    import shps_pkg::*;

    // hold a stalled request
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind)
            && $stable(res_slot) && $stable(res_run_last))
        else $error("result request changed while stalled");

    // frame summary is always the final record of its byte
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_DONE |-> res_run_last && res_slot == '0
            && res_packet_count <= COUNT_W'(MAX_SLOTS))
        else $error("frame summary malformed");

    a_store_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_STORE |->
            res_offset < OFFSET_W'(MAX_PACKET_LEN) && res_slot < SLOT_W'(MAX_SLOTS))
        else $error("stored byte out of range");

    a_close_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_CLOSE |->
            res_packet_length >= LEN_W'(2)
            && res_packet_length <= LEN_W'(MAX_PACKET_LEN))
        else $error("closed packet length out of range");

endmodule

bind sync_header_packet_splitter shps_checker u_shps_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_kind          (res.kind),
    .res_slot          (res.slot),
    .res_offset        (res.offset),
    .res_packet_length (res.packet_length),
    .res_packet_count  (res.packet_count),
    .res_run_last      (res.run_last)
);
`default_nettype wire
